/* rtl/dda_line_rasterizer_macros.svh */
// Assertion macros shared by the checkers of the DDA line rasterizer.
// Depends on nothing; the files that assert include it by name.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLR_ASSERT_SAME(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("dda_line_rasterizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DLR_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("dda_line_rasterizer: next-cycle check failed");

`endif

/* rtl/dlr_pkg.sv */
// Shared constants, types and the pixel rounding function of the DDA line rasterizer.
// Depends on nothing; every file but the macros header imports it.
package dlr_pkg;

    // Number formats.
    localparam int COORD_BITS     = 16;
    localparam int SUBPIXEL_BITS  = 4;
    localparam int STEP_FRAC_BITS = 16;

    localparam int SCALE_SHIFT = STEP_FRAC_BITS - SUBPIXEL_BITS;
    localparam int DELTA_W     = COORD_BITS + 1;
    localparam int STEPS_W     = COORD_BITS - SUBPIXEL_BITS + 1;
    localparam int STEP_W      = STEP_FRAC_BITS + 2;
    localparam int T_W         = STEP_FRAC_BITS + 1;
    localparam int POS_W       = COORD_BITS + SCALE_SHIFT + 2;
    localparam int DIVIDEND_W  = (COORD_BITS + SCALE_SHIFT > T_W) ?
                                 (COORD_BITS + SCALE_SHIFT) : T_W;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

    // Field widths of the stream words.
    localparam int PIX_W       = 13;
    localparam int ID_W        = 16;
    localparam int S_TDATA_W   = 4 * COORD_BITS + ID_W;
    localparam int M_FIELDS_W  = 2 * PIX_W + T_W + ID_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] ROUND_HALF = POS_W'(1) << (STEP_FRAC_BITS - 1);
    localparam logic [DELTA_W:0] SUB_ROUND  = (DELTA_W + 1)'((1 << SUBPIXEL_BITS) - 1);

    // Input word kinds carried on tuser.
    typedef enum logic [0:0] {
        CMD_BEGIN   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // Line setup sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEPS,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_T
    } state_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Round a fixed-point position half away from zero to whole pixels.
    function automatic logic [PIX_W-1:0] round_pix(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] sum;
        logic [PIX_W-1:0] r;
        mag = p[POS_W-1] ? (~p + POS_W'(1)) : p;
        sum = mag + ROUND_HALF;
        r   = PIX_W'(sum >> STEP_FRAC_BITS);
        return p[POS_W-1] ? (~r + PIX_W'(1)) : r;
    endfunction

endpackage

/* rtl/dlr_div.sv */
// Restoring serial divider, one quotient bit per cycle, shared by the three increments.
// Depends on dlr_pkg.
module dlr_div import dlr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [STEPS_W-1:0]    divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [STEPS_W-1:0]    rem_reg, rem_next;
    logic [STEPS_W-1:0]    dvs_reg, dvs_next;
    logic [STEPS_W+1:0]    trial;
    logic                  fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        trial = {1'b0, rem_reg, dvd_reg[DIVIDEND_W-1]} - {2'b00, dvs_reg};
        fits  = ~trial[STEPS_W+1];
    end

    // Iteration control; the dividend register fills with quotient bits from the bottom.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? trial[STEPS_W-1:0] : {rem_reg[STEPS_W-2:0], dvd_reg[DIVIDEND_W-1]};
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule

/* rtl/dda_line_rasterizer.sv */
// Top level of the DDA line rasterizer: setup sequencer, line walker and output register.
// Depends on dlr_pkg and dlr_div.
//
// A begin word (tuser 0) loads a line and keeps s_axis_tready low during setup: the
// ST_STEPS state sizes the line, then the single serial divider runs three times, once
// each for the x, y and t increments, at one quotient bit per cycle. An advance word
// (tuser 1) puts one fragment into the output register; with m_axis_tready held high,
// advances go through at one word per cycle. A line gives steps+1 fragments, the final
// one with m_axis_tlast set; an advance with no line in progress gives nothing. A begin
// word abandons any line still in progress.
module dda_line_rasterizer import dlr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x, start_y, end_x, end_y, prim_id (lowest bits first)
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pix_x, pix_y, param_t, frag_prim_id, zero fill (lowest bits first)
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    state_t                state_reg, state_next;
    logic                  active_reg, active_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [COORD_BITS-1:0] sx_reg, sx_next;
    logic [COORD_BITS-1:0] sy_reg, sy_next;
    logic [DELTA_W-1:0]    dx_reg, dx_next;
    logic [DELTA_W-1:0]    dy_reg, dy_next;
    logic [STEPS_W-1:0]    steps_reg, steps_next;
    logic [POS_W-1:0]      pos_x_reg, pos_x_next;
    logic [POS_W-1:0]      pos_y_reg, pos_y_next;
    logic [STEP_W-1:0]     step_x_reg, step_x_next;
    logic [STEP_W-1:0]     step_y_reg, step_y_next;
    logic [T_W-1:0]        t_accum_reg, t_accum_next;
    logic [T_W-1:0]        t_step_reg, t_step_next;
    logic [STEPS_W-1:0]    remaining_reg, remaining_next;
    logic [ID_W-1:0]       held_id_reg, held_id_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  s_ready;
    logic                  s_accept;
    logic [COORD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
    logic [ID_W-1:0]       in_id;
    logic [DELTA_W-1:0]    ax, ay, amax;
    logic [DELTA_W:0]      steps_sum;
    logic [STEPS_W-1:0]    steps_raw;
    logic [STEP_W-1:0]     quo_trim;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    div_status_t           div_status;
    logic [DIVIDEND_W-1:0] div_quotient;

    // Input word fields.
    assign in_sx = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_sy = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_ex = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_ey = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_id = s_axis_tdata[4*COORD_BITS +: ID_W];

    // A word is taken only when idle and the output register is free or draining.
    assign s_ready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_axis_tready);
    assign s_accept = s_axis_tvalid && s_ready;

    // Line length in whole pixels, rounded up, at least one step.
    always_comb begin
        ax        = dx_reg[DELTA_W-1] ? (~dx_reg + DELTA_W'(1)) : dx_reg;
        ay        = dy_reg[DELTA_W-1] ? (~dy_reg + DELTA_W'(1)) : dy_reg;
        amax      = (ax > ay) ? ax : ay;
        steps_sum = {1'b0, amax} + SUB_ROUND;
        steps_raw = STEPS_W'(steps_sum >> SUBPIXEL_BITS);
        quo_trim  = STEP_W'(div_quotient);
    end

    // Setup sequencer and fragment walker.
    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        steps_next     = steps_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        t_accum_next   = t_accum_reg;
        t_step_next    = t_step_reg;
        remaining_next = remaining_reg;
        held_id_next   = held_id_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        div_start      = 1'b0;
        div_dividend   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser == CMD_BEGIN) begin
                        // Latch the endpoints and the id; the old line is dropped.
                        sx_next      = in_sx;
                        sy_next      = in_sy;
                        dx_next      = {in_ex[COORD_BITS-1], in_ex} - {in_sx[COORD_BITS-1], in_sx};
                        dy_next      = {in_ey[COORD_BITS-1], in_ey} - {in_sy[COORD_BITS-1], in_sy};
                        held_id_next = in_id;
                        active_next  = 1'b0;
                        state_next   = ST_STEPS;
                    end else if (active_reg) begin
                        // Emit the fragment at the current position, then walk one step.
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = M_TDATA_W'({held_id_reg, t_accum_reg,
                                                    round_pix(pos_y_reg),
                                                    round_pix(pos_x_reg)});
                        m_tlast_next  = (remaining_reg == '0);
                        if (remaining_reg == '0) begin
                            active_next = 1'b0;
                        end else begin
                            pos_x_next = pos_x_reg +
                                {{(POS_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
                            pos_y_next = pos_y_reg +
                                {{(POS_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
                            t_accum_next   = t_accum_reg + t_step_reg;
                            remaining_next = remaining_reg - STEPS_W'(1);
                        end
                    end
                end
            end
            ST_STEPS: begin
                // Step count and start position.
                steps_next     = (steps_raw == '0) ? STEPS_W'(1) : steps_raw;
                remaining_next = (steps_raw == '0) ? STEPS_W'(1) : steps_raw;
                pos_x_next     = {{(POS_W-COORD_BITS-SCALE_SHIFT){sx_reg[COORD_BITS-1]}},
                                  sx_reg, {SCALE_SHIFT{1'b0}}};
                pos_y_next     = {{(POS_W-COORD_BITS-SCALE_SHIFT){sy_reg[COORD_BITS-1]}},
                                  sy_reg, {SCALE_SHIFT{1'b0}}};
                t_accum_next   = '0;
                state_next     = ST_DIV_X;
            end
            ST_DIV_X: begin
                // Divide the magnitude and put the sign back: truncation toward zero.
                div_dividend = DIVIDEND_W'({ax[COORD_BITS-1:0], {SCALE_SHIFT{1'b0}}});
                div_start    = !div_status.busy && !div_status.done;
                if (div_status.done) begin
                    step_x_next = dx_reg[DELTA_W-1] ? (~quo_trim + STEP_W'(1)) : quo_trim;
                    state_next  = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                div_dividend = DIVIDEND_W'({ay[COORD_BITS-1:0], {SCALE_SHIFT{1'b0}}});
                div_start    = !div_status.busy && !div_status.done;
                if (div_status.done) begin
                    step_y_next = dy_reg[DELTA_W-1] ? (~quo_trim + STEP_W'(1)) : quo_trim;
                    state_next  = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                div_dividend = DIVIDEND_W'(1) << STEP_FRAC_BITS;
                div_start    = !div_status.busy && !div_status.done;
                if (div_status.done) begin
                    t_step_next = T_W'(div_quotient);
                    active_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shared serial divider.
    dlr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (steps_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Control and line state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            t_accum_reg   <= '0;
            t_step_reg    <= '0;
            remaining_reg <= '0;
            held_id_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            m_tvalid_reg  <= m_tvalid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            t_accum_reg   <= t_accum_next;
            t_step_reg    <= t_step_next;
            remaining_reg <= remaining_next;
            held_id_reg   <= held_id_next;
        end
    end

    // Setup and output payload registers.
    always_ff @(posedge aclk) begin
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        steps_reg   <= steps_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_axis_tready = s_ready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

endmodule

/* rtl/dlr_checker.sv */
// Port-level assertions for the DDA line rasterizer, bound to the top level.
// Depends on dlr_pkg and dda_line_rasterizer_macros.svh.
`include "dda_line_rasterizer_macros.svh"

module dlr_checker import dlr_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // A stalled result word holds its value.
    `DLR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // A begin word starts the setup, so the input side closes right after it.
    `DLR_ASSERT_NEXT(a_begin_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_BEGIN, !s_axis_tready)

    // A new result word only follows an accepted advance word.
    `DLR_ASSERT_SAME(a_out_cause, aclk, aresetn, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_ADVANCE))

    // The input side is open only when the output register can take a word.
    `DLR_ASSERT_SAME(a_ready_room, aclk, aresetn, s_axis_tready, !m_axis_tvalid || m_axis_tready)

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (.*);
